>>> src/hfp_pkg.sv
// Shared types and constants for the Huffman bit packer.
package hfp_pkg;

    localparam int CODE_W      = 32;
    localparam int LEN_W       = 6;
    localparam int SYM_W       = 8;
    localparam int BYTE_W      = 8;
    localparam int VBITS_W     = 4;
    localparam int ACC_W       = CODE_W + BYTE_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic {
        KIND_ENCODE = 1'b0,
        KIND_FLUSH  = 1'b1
    } t_kind;

    // code is left aligned: first code bit sits in bit CODE_W-1
    typedef struct packed {
        t_kind              kind;
        logic [CODE_W-1:0]  code;
        logic [LEN_W-1:0]   len;
    } t_queue_entry;

endpackage

>>> src/hfp_front.sv
// Front end: accepts requests, owns the code table, classifies work for the back end.
module hfp_front #(
    parameter int MAX_CODE_LEN = 32,
    parameter int NUM_SYMBOLS  = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_op,
    input  logic [hfp_pkg::SYM_W-1:0]   i_symbol,
    input  logic [hfp_pkg::CODE_W-1:0]  i_code_bits,
    input  logic [hfp_pkg::LEN_W-1:0]   i_code_length,
    output logic                        o_push,
    output hfp_pkg::t_queue_entry       o_entry,
    input  logic                        i_full
);

    localparam int IDX_W   = $clog2(NUM_SYMBOLS);
    localparam int EFF_MAX = (MAX_CODE_LEN < hfp_pkg::CODE_W) ? MAX_CODE_LEN : hfp_pkg::CODE_W;
    localparam int ENTRY_W = hfp_pkg::LEN_W + hfp_pkg::CODE_W;

    logic [ENTRY_W-1:0]          r_mem [NUM_SYMBOLS];
    logic [ENTRY_W-1:0]          r_rd;
    logic                        r_s1_valid;
    hfp_pkg::t_op                r_s1_op;
    logic                        r_s1_in_range;

    hfp_pkg::t_op                op;
    logic                        accept;
    logic                        in_range;
    logic [IDX_W-1:0]            idx;
    logic [hfp_pkg::LEN_W-1:0]   len_sat;
    logic [hfp_pkg::CODE_W-1:0]  code_la;
    logic                        we;
    logic [hfp_pkg::LEN_W-1:0]   rd_len;
    logic [hfp_pkg::CODE_W-1:0]  rd_code;
    logic                        push_enc;
    logic                        push_fl;
    logic                        need_push;
    logic                        s1_free;

    assign op       = hfp_pkg::t_op'(i_op);
    assign in_range = {1'b0, i_symbol} < (hfp_pkg::SYM_W+1)'(NUM_SYMBOLS);
    assign idx      = i_symbol[IDX_W-1:0];
    assign len_sat  = (i_code_length > hfp_pkg::LEN_W'(EFF_MAX)) ?
                      hfp_pkg::LEN_W'(EFF_MAX) : i_code_length;
    // left align; bits above the length fall off the top, length zero stores zero
    assign code_la  = i_code_bits << (hfp_pkg::LEN_W'(hfp_pkg::CODE_W) - len_sat);

    assign accept = i_valid && o_ready;
    assign we     = accept && (op == hfp_pkg::OP_LOAD) && in_range;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[idx] <= {len_sat, code_la};
        end
        if (accept) begin
            r_rd <= r_mem[idx];
        end
    end

    assign rd_len  = r_rd[ENTRY_W-1 -: hfp_pkg::LEN_W];
    assign rd_code = r_rd[hfp_pkg::CODE_W-1:0];

    assign push_enc  = (r_s1_op == hfp_pkg::OP_ENCODE) && r_s1_in_range && (rd_len != '0);
    assign push_fl   = (r_s1_op == hfp_pkg::OP_FLUSH);
    assign need_push = push_enc || push_fl;
    assign s1_free   = !r_s1_valid || !need_push || !i_full;
    assign o_ready   = s1_free;
    assign o_push    = r_s1_valid && need_push && !i_full;

    always_comb begin
        o_entry.kind = push_fl ? hfp_pkg::KIND_FLUSH : hfp_pkg::KIND_ENCODE;
        o_entry.code = rd_code;
        o_entry.len  = rd_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_free) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op       <= op;
            r_s1_in_range <= in_range;
        end
    end

endmodule

>>> src/hfp_fifo.sv
// Short queue between the front end and the packing back end.
module hfp_fifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  hfp_pkg::t_queue_entry  i_entry,
    output logic                   o_full,
    input  logic                   i_pop,
    output hfp_pkg::t_queue_entry  o_entry,
    output logic                   o_empty
);

    hfp_pkg::t_queue_entry             r_mem [hfp_pkg::QUEUE_DEPTH];
    logic [hfp_pkg::QPTR_W-1:0]        r_wptr;
    logic [hfp_pkg::QPTR_W-1:0]        r_rptr;
    logic [hfp_pkg::QCNT_W-1:0]        r_count;

    assign o_full  = (r_count == hfp_pkg::QCNT_W'(hfp_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> src/hfp_back.sv
// Back end: merges codes into the bit accumulator and emits one byte per cycle while i_ready allows.
module hfp_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hfp_pkg::t_queue_entry         i_entry,
    input  logic                          i_empty,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [hfp_pkg::BYTE_W-1:0]    o_out_byte,
    output logic [hfp_pkg::VBITS_W-1:0]   o_valid_bits,
    output logic                          o_last
);

    // r_acc holds unsent bits MSB first; below 8 bits it is the pending byte
    logic [hfp_pkg::ACC_W-1:0]    r_acc;
    logic [hfp_pkg::LEN_W-1:0]    r_cnt;
    logic                         r_out_valid;
    logic [hfp_pkg::BYTE_W-1:0]   r_out_byte;
    logic [hfp_pkg::VBITS_W-1:0]  r_out_vbits;
    logic                         r_out_last;

    logic [hfp_pkg::ACC_W-1:0]    w_acc;
    logic [hfp_pkg::LEN_W-1:0]    w_cnt;
    logic [hfp_pkg::ACC_W-1:0]    n_acc;
    logic [hfp_pkg::LEN_W-1:0]    n_cnt;
    logic                         can_out;
    logic                         flush_out;
    logic                         emit;
    logic [hfp_pkg::BYTE_W-1:0]   emit_byte;
    logic [hfp_pkg::VBITS_W-1:0]  emit_vbits;
    logic                         emit_last;

    assign can_out = !r_out_valid || i_ready;

    always_comb begin
        o_pop     = 1'b0;
        flush_out = 1'b0;
        w_acc     = r_acc;
        w_cnt     = r_cnt;
        if ((r_cnt < hfp_pkg::LEN_W'(hfp_pkg::BYTE_W)) && !i_empty) begin
            if (i_entry.kind == hfp_pkg::KIND_FLUSH) begin
                if (r_cnt == '0) begin
                    o_pop = 1'b1;
                end else if (can_out) begin
                    o_pop     = 1'b1;
                    flush_out = 1'b1;
                end
            end else begin
                o_pop = 1'b1;
                w_acc = r_acc | ({i_entry.code, {hfp_pkg::BYTE_W{1'b0}}} >> r_cnt[2:0]);
                w_cnt = r_cnt + i_entry.len;
            end
        end
    end

    always_comb begin
        n_acc      = w_acc;
        n_cnt      = w_cnt;
        emit       = 1'b0;
        emit_byte  = w_acc[hfp_pkg::ACC_W-1 -: hfp_pkg::BYTE_W];
        emit_vbits = hfp_pkg::VBITS_W'(hfp_pkg::BYTE_W);
        emit_last  = 1'b0;
        if (flush_out) begin
            emit       = 1'b1;
            emit_byte  = r_acc[hfp_pkg::ACC_W-1 -: hfp_pkg::BYTE_W];
            emit_vbits = {1'b0, r_cnt[2:0]};
            emit_last  = 1'b1;
            n_acc      = '0;
            n_cnt      = '0;
        end else if ((w_cnt >= hfp_pkg::LEN_W'(hfp_pkg::BYTE_W)) && can_out) begin
            emit      = 1'b1;
            n_cnt     = w_cnt - hfp_pkg::LEN_W'(hfp_pkg::BYTE_W);
            emit_last = (n_cnt < hfp_pkg::LEN_W'(hfp_pkg::BYTE_W));
            n_acc     = w_acc << hfp_pkg::BYTE_W;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc <= n_acc;
            r_cnt <= n_cnt;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte  <= emit_byte;
            r_out_vbits <= emit_vbits;
            r_out_last  <= emit_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_valid_bits = r_out_vbits;
    assign o_last       = r_out_last;

    a_pop_only_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_cnt < hfp_pkg::LEN_W'(hfp_pkg::BYTE_W)))
        else $error("queue popped while full bytes still pending");

    a_pad_bits_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt < hfp_pkg::LEN_W'(hfp_pkg::BYTE_W)) |-> (r_acc[hfp_pkg::CODE_W-1:0] == '0))
        else $error("stale bits below the pending byte");

    a_partial_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_valid_bits != hfp_pkg::VBITS_W'(hfp_pkg::BYTE_W))) |-> o_last)
        else $error("partial byte without last");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && (i_entry.kind == hfp_pkg::KIND_FLUSH)) |=> (r_cnt == '0))
        else $error("pending bits survive a flush");

endmodule

>>> src/huffman_bit_packer.sv
// Huffman encoder bit packer: top level.
// A request's bytes pass the table read register, the queue and the output byte register.
// Throughput: one request per cycle while each yields at most one byte and i_ready is high;
// an encode that yields more bytes holds the packer, set by the single output byte register.
// A 4-entry queue lets the table lookup run ahead of the packer.
// Reset clears control and pending bits; the code table is undefined until loaded.
module huffman_bit_packer #(
    parameter int MAX_CODE_LEN = 32,
    parameter int NUM_SYMBOLS  = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [1:0]                     i_op,
    input  logic [hfp_pkg::SYM_W-1:0]      i_symbol,
    input  logic [hfp_pkg::CODE_W-1:0]     i_code_bits,
    input  logic [hfp_pkg::LEN_W-1:0]      i_code_length,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [hfp_pkg::BYTE_W-1:0]     o_out_byte,
    output logic [hfp_pkg::VBITS_W-1:0]    o_valid_bits,
    output logic                           o_last
);

    logic                   push;
    logic                   pop;
    logic                   full;
    logic                   empty;
    hfp_pkg::t_queue_entry  push_entry;
    hfp_pkg::t_queue_entry  pop_entry;

    hfp_front #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .NUM_SYMBOLS  (NUM_SYMBOLS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_op          (i_op),
        .i_symbol      (i_symbol),
        .i_code_bits   (i_code_bits),
        .i_code_length (i_code_length),
        .o_push        (push),
        .o_entry       (push_entry),
        .i_full        (full)
    );

    hfp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_entry (pop_entry),
        .o_empty (empty)
    );

    hfp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_entry      (pop_entry),
        .i_empty      (empty),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_byte   (o_out_byte),
        .o_valid_bits (o_valid_bits),
        .o_last       (o_last)
    );

endmodule

>>> tb/sv/huffman_bit_packer_tb.sv
// Self-checking testbench for the Huffman bit packer: table loads, encodes and flushes.
`timescale 1ns / 1ps

module huffman_bit_packer_tb;

    localparam int MAX_LEN   = 32;
    localparam int NUM_SYM   = 256;
    localparam int RAND_REQS = 245;
    localparam int QUIET_REQS = 40;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        hfp_pkg::t_op                op;
        logic [hfp_pkg::SYM_W-1:0]   sym;
        logic [hfp_pkg::CODE_W-1:0]  code;
        logic [hfp_pkg::LEN_W-1:0]   len;
    } t_pack_req;

    typedef struct {
        logic [hfp_pkg::BYTE_W-1:0]  data;
        logic [hfp_pkg::VBITS_W-1:0] vbits;
        logic                        last;
    } t_packed_byte;

    logic                        i_clk         = 1'b0;
    logic                        i_rst_n       = 1'b0;
    logic                        i_valid       = 1'b0;
    logic                        o_ready;
    logic [1:0]                  i_op          = hfp_pkg::OP_NONE;
    logic [hfp_pkg::SYM_W-1:0]   i_symbol      = '0;
    logic [hfp_pkg::CODE_W-1:0]  i_code_bits   = '0;
    logic [hfp_pkg::LEN_W-1:0]   i_code_length = '0;
    logic                        o_valid;
    logic                        i_ready       = 1'b0;
    logic [hfp_pkg::BYTE_W-1:0]  o_out_byte;
    logic [hfp_pkg::VBITS_W-1:0] o_valid_bits;
    logic                        o_last;

    t_pack_req    pending_reqs[$];
    t_packed_byte expected_bytes[$];
    t_pack_req    cur_req;
    t_packed_byte want_byte;

    // predictor state
    logic [hfp_pkg::CODE_W-1:0]  code_tab [NUM_SYM];
    logic [hfp_pkg::LEN_W-1:0]   len_tab  [NUM_SYM];
    logic [hfp_pkg::BYTE_W-1:0]  fill_byte = '0;
    int                          fill_cnt  = 0;

    // generator bookkeeping
    bit                 gen_loaded [NUM_SYM];
    int                 loaded_syms[$];

    int total_reqs = 0;
    int sent_cnt   = 0;
    int send_gap   = 0;
    int recv_gap   = 0;
    int errors     = 0;
    bit quiet;

    huffman_bit_packer #(
        .MAX_CODE_LEN(MAX_LEN),
        .NUM_SYMBOLS (NUM_SYM)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_op         (i_op),
        .i_symbol     (i_symbol),
        .i_code_bits  (i_code_bits),
        .i_code_length(i_code_length),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_byte   (o_out_byte),
        .o_valid_bits (o_valid_bits),
        .o_last       (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    assign quiet = (sent_cnt >= total_reqs - QUIET_REQS);

    // Works out the bytes one accepted request produces and queues them.
    function automatic void pack_request(t_pack_req req);
        t_packed_byte res[4];
        int           n;
        int           l;
        logic [hfp_pkg::CODE_W-1:0] c;
        n = 0;
        case (req.op)
            hfp_pkg::OP_LOAD: begin
                l = (int'(req.len) > MAX_LEN) ? MAX_LEN : int'(req.len);
                code_tab[req.sym] = req.code & ~({hfp_pkg::CODE_W{1'b1}} << l);
                len_tab[req.sym]  = hfp_pkg::LEN_W'(l);
            end
            hfp_pkg::OP_ENCODE: begin
                c = code_tab[req.sym];
                l = int'(len_tab[req.sym]);
                for (int i = l; i > 0; i--) begin
                    fill_byte[7 - fill_cnt] = c[i - 1];
                    fill_cnt++;
                    if (fill_cnt == hfp_pkg::BYTE_W) begin
                        res[n] = '{data: fill_byte,
                                   vbits: hfp_pkg::VBITS_W'(hfp_pkg::BYTE_W),
                                   last: 1'b0};
                        n++;
                        fill_byte = '0;
                        fill_cnt  = 0;
                    end
                end
                if (n > 0)
                    res[n - 1].last = 1'b1;
                for (int k = 0; k < n; k++)
                    expected_bytes.push_back(res[k]);
            end
            hfp_pkg::OP_FLUSH: begin
                if (fill_cnt != 0) begin
                    expected_bytes.push_back('{data: fill_byte,
                                               vbits: hfp_pkg::VBITS_W'(fill_cnt),
                                               last: 1'b1});
                    fill_byte = '0;
                    fill_cnt  = 0;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void add_req(hfp_pkg::t_op op, int sym,
                                    logic [hfp_pkg::CODE_W-1:0] code, int len);
        t_pack_req r;
        r = '{op: op, sym: hfp_pkg::SYM_W'(sym), code: code, len: hfp_pkg::LEN_W'(len)};
        if (op == hfp_pkg::OP_LOAD && !gen_loaded[sym]) begin
            gen_loaded[sym] = 1'b1;
            loaded_syms.push_back(sym);
        end
        pending_reqs.push_back(r);
    endfunction

    // mostly short codes, with some long, saturating and empty ones
    function automatic int pick_len();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 65)
            return $urandom_range(1, 12);
        else if (sel < 82)
            return $urandom_range(13, 32);
        else if (sel < 92)
            return $urandom_range(33, 63);
        else if (sel < 96)
            return 32;
        else
            return 0;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                pack_request(cur_req);
                sent_cnt++;
            end
            if (!i_valid || o_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    cur_req = pending_reqs.pop_front();
                    i_valid       <= 1'b1;
                    i_op          <= cur_req.op;
                    i_symbol      <= cur_req.sym;
                    i_code_bits   <= cur_req.code;
                    i_code_length <= cur_req.len;
                    if (!quiet && $urandom_range(0, 6) == 0)
                        send_gap = $urandom_range(1, 14);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor and receiver stalls
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_bytes.size() == 0) begin
                    $error("unexpected byte %02h valid_bits %0d last %0b",
                           o_out_byte, o_valid_bits, o_last);
                    errors++;
                end else begin
                    want_byte = expected_bytes.pop_front();
                    if (o_out_byte !== want_byte.data) begin
                        $error("out_byte: expected %02h, got %02h", want_byte.data, o_out_byte);
                        errors++;
                    end
                    if (o_valid_bits !== want_byte.vbits) begin
                        $error("valid_bits: expected %0d, got %0d",
                               want_byte.vbits, o_valid_bits);
                        errors++;
                    end
                    if (o_last !== want_byte.last) begin
                        $error("last: expected %0b, got %0b", want_byte.last, o_last);
                        errors++;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 6) == 0)
                    recv_gap = $urandom_range(1, 14);
            end
        end
    end

    initial begin
        int sel;
        int cnt;

        // directed: empty flush, unused op, zero and saturated lengths, dropped code bits
        add_req(hfp_pkg::OP_FLUSH,  0,   32'h0000_0000, 0);
        add_req(hfp_pkg::OP_NONE,   255, 32'hFFFF_FFFF, 63);
        add_req(hfp_pkg::OP_LOAD,   0,   32'hFFFF_FFFF, 0);
        add_req(hfp_pkg::OP_ENCODE, 0,   32'h0000_0000, 0);
        add_req(hfp_pkg::OP_LOAD,   255, 32'hFFFF_FFFF, 32);
        add_req(hfp_pkg::OP_ENCODE, 255, 32'h0000_0000, 0);
        add_req(hfp_pkg::OP_LOAD,   1,   32'h0000_0000, 63);
        add_req(hfp_pkg::OP_ENCODE, 1,   32'hFFFF_FFFF, 63);
        add_req(hfp_pkg::OP_LOAD,   2,   32'hFFFF_FFF5, 3);
        add_req(hfp_pkg::OP_ENCODE, 2,   32'h0000_0000, 0);
        add_req(hfp_pkg::OP_FLUSH,  0,   32'h0000_0000, 0);
        add_req(hfp_pkg::OP_ENCODE, 2,   32'h0000_0000, 0);
        add_req(hfp_pkg::OP_ENCODE, 255, 32'h0000_0000, 0);
        add_req(hfp_pkg::OP_FLUSH,  0,   32'h0000_0000, 0);
        add_req(hfp_pkg::OP_LOAD,   128, 32'h8000_0001, 33);
        add_req(hfp_pkg::OP_ENCODE, 128, 32'h0000_0000, 0);
        add_req(hfp_pkg::OP_LOAD,   3,   32'h0000_0001, 1);
        for (int i = 0; i < 7; i++)
            add_req(hfp_pkg::OP_ENCODE, 3, 32'h0000_0000, 0);
        add_req(hfp_pkg::OP_FLUSH,  0,   32'h0000_0000, 0);

        // random: well-formed load/encode traffic with flushes and unused-op noise
        cnt = 0;
        while (cnt < RAND_REQS) begin
            sel = $urandom_range(0, 99);
            if (sel < 28 || loaded_syms.size() == 0) begin
                add_req(hfp_pkg::OP_LOAD, $urandom_range(0, NUM_SYM - 1), $urandom,
                        pick_len());
            end else if (sel < 88) begin
                add_req(hfp_pkg::OP_ENCODE,
                        loaded_syms[$urandom_range(0, loaded_syms.size() - 1)],
                        $urandom, $urandom_range(0, 63));
            end else if (sel < 96) begin
                add_req(hfp_pkg::OP_FLUSH, $urandom_range(0, NUM_SYM - 1), $urandom,
                        $urandom_range(0, 63));
            end else begin
                add_req(hfp_pkg::OP_NONE, $urandom_range(0, NUM_SYM - 1), $urandom,
                        $urandom_range(0, 63));
            end
            cnt++;
        end
        add_req(hfp_pkg::OP_FLUSH, 0, 32'h0000_0000, 0);
        total_reqs = pending_reqs.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || i_valid || expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #400000;
        $display("simulation failed");
        $finish;
    end

endmodule
